### hw/rtl/dmx_pkg.sv
// Shared types, constants and colour helpers for the dot-matrix 4x expander.
// No dependencies; imported by every module of the block.
`default_nettype none

package dmx_pkg;

    // Fixed geometry
    localparam int SCALE      = 4;
    localparam int SUB_W      = 2;          // bits of a block row or column
    localparam int K_W        = 4;          // bits of the in-block pixel index
    localparam int COORD_W    = 13;         // output coordinate width
    localparam int DIM_W      = 12;         // frame_width / frame_height width
    localparam int PIX_W      = 32;
    localparam int TINT_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 64;

    // Per-channel low-bit masks for the packed average
    localparam logic [PIX_W-1:0] MASK_565    = 32'h0000_0821;
    localparam logic [PIX_W-1:0] MASK_8888   = 32'h0101_0101;
    localparam logic [PIX_W-1:0] LOW16_MASK  = 32'h0000_FFFF;

    // Register reset values
    localparam logic              FORMAT_RST = 1'b1;
    localparam logic [TINT_W-1:0] TINT_RST   = 24'hFF_FFFF;
    localparam logic [DIM_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 12'd480;

    // Special in-block indices (top-left and bottom-right grid dots)
    localparam logic [K_W-1:0] K_FIRST = 4'd0;
    localparam logic [K_W-1:0] K_LAST  = 4'd15;
    localparam logic [SUB_W-1:0] SUB_FIRST = 2'd0;
    localparam logic [SUB_W-1:0] SUB_LAST  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_GRID_TINT    = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              wide;          // 1 = XRGB8888, 0 = RGB565
        logic [TINT_W-1:0] tint;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } cfg_t;

    // One classified source pixel, ready for block expansion
    typedef struct packed {
        logic [PIX_W-1:0]   pix_p;
        logic [PIX_W-1:0]   pix_g;
        logic [PIX_W-1:0]   pix_s;
        logic [COORD_W-1:0] col_base;
        logic [COORD_W-1:0] row_base;
    } blk_entry_t;

    // Packed per-channel average, rounded up or down.
    // RGB565 keeps the carry out of bit 15; XRGB8888 wraps at 32 bits.
    function automatic logic [PIX_W-1:0] pix_avg(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic wide,
                                                 input logic up);
        logic [PIX_W:0] corr;
        logic [PIX_W:0] sum;
        corr = {1'b0, (a ^ b) & (wide ? MASK_8888 : MASK_565)};
        if (up) begin
            sum = {1'b0, a} + {1'b0, b} + corr;
        end else begin
            sum = {1'b0, a} + {1'b0, b} - corr;
        end
        if (wide) begin
            return {1'b0, sum[PIX_W-1:1]};
        end
        return {16'h0000, sum[16:1]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dot_matrix_4x_pixel_expander.sv
// Top level of the dot-matrix 4x pixel expander: configuration registers,
// front end, block queue and back end. Uses dmx_pkg, dmx_front, dmx_fifo, dmx_back.
//
// Each source pixel (RGB565 in the low 16 bits or XRGB8888) becomes the 16
// pixels of a 4x4 dot-matrix block, emitted in block raster order with the
// output-frame column and row; tlast marks the last pixel of each block. The
// output port gives one pixel per cycle while m_tready is high and blocks are
// queued. New source requests are taken while earlier blocks are still being
// emitted: a three-stage colour pipeline and a two-entry queue sit before the
// output, so up to five source pixels can be held while the output is stalled.
// The first output pixel of a request passes through the three colour stages,
// the queue and the output register. Configuration must be written through the
// plain write port only while the block is idle; the block itself does not
// enforce this, and the source coordinate counters are never cleared by a write.
`default_nettype none

module dot_matrix_4x_pixel_expander #(
    parameter int WIDTH_LIMIT  = 2048,
    parameter int HEIGHT_LIMIT = 2048
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [dmx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dmx_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // Source pixel stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dmx_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] src_pixel
    // Output pixel stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dmx_pkg::M_TDATA_W-1:0]          m_tdata,   // [31:0] out_pixel,
                                                              // [44:32] out_col,
                                                              // [57:45] out_row
    output logic                                   m_tlast    // block_last
);
    import dmx_pkg::*;

    logic              wide_reg;
    logic [TINT_W-1:0] tint_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    cfg_t              cfg;

    logic       q_in_valid, q_in_ready, q_out_valid, q_pop;
    blk_entry_t q_in_entry, q_out_entry;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg   <= FORMAT_RST;
            tint_reg   <= TINT_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PIXEL_FORMAT: wide_reg   <= cfg_wr_data[0];
                REG_GRID_TINT:    tint_reg   <= cfg_wr_data[TINT_W-1:0];
                REG_FRAME_WIDTH:  width_reg  <= cfg_wr_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_wr_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.wide   = wide_reg;
    assign cfg.tint   = tint_reg;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    dmx_front #(
        .WIDTH_LIMIT  (WIDTH_LIMIT),
        .HEIGHT_LIMIT (HEIGHT_LIMIT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_pixel (s_tdata),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_entry  (q_in_entry)
    );

    dmx_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_entry (q_in_entry),
        .rd_valid (q_out_valid),
        .rd_pop   (q_pop),
        .rd_entry (q_out_entry)
    );

    dmx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_out_valid),
        .q_pop    (q_pop),
        .q_entry  (q_out_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/dmx_front.sv
// Front end: takes source pixel requests, tracks the source coordinate and
// derives grid and shadow colours over three register stages. Uses dmx_pkg.
`default_nettype none

module dmx_front #(
    parameter int WIDTH_LIMIT  = 2048,
    parameter int HEIGHT_LIMIT = 2048
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dmx_pkg::cfg_t                  cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [dmx_pkg::PIX_W-1:0]      in_pixel,
    output logic                                q_valid,
    input  wire logic                           q_ready,
    output dmx_pkg::blk_entry_t                 q_entry
);
    import dmx_pkg::*;

    localparam int CW = (WIDTH_LIMIT  > 1) ? $clog2(WIDTH_LIMIT)  : 1;
    localparam int RW = (HEIGHT_LIMIT > 1) ? $clog2(HEIGHT_LIMIT) : 1;
    localparam int EW = DIM_W + 1;
    localparam int CMP_W = EW + 1;

    // Source coordinate counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [EW-1:0] eff_w, eff_h;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;

    // Stage registers
    logic               st0_valid_reg, st0_valid_next;
    logic               st1_valid_reg, st1_valid_next;
    logic               st2_valid_reg, st2_valid_next;
    logic [PIX_W-1:0]   st0_p_reg, st1_p_reg, st2_p_reg;
    logic [PIX_W-1:0]   st1_g_reg, st2_g_reg, st2_mix_reg;
    logic [COORD_W-1:0] st0_col_reg, st1_col_reg, st2_col_reg;
    logic [COORD_W-1:0] st0_row_reg, st1_row_reg, st2_row_reg;

    logic             accept, adv0, adv1, adv2, rdy1, rdy2;
    logic [PIX_W-1:0] base, p_in;

    // Effective frame size: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (cfg.width == '0) begin
            eff_w = EW'(1);
        end else if ({1'b0, cfg.width} > EW'(WIDTH_LIMIT)) begin
            eff_w = EW'(WIDTH_LIMIT);
        end else begin
            eff_w = {1'b0, cfg.width};
        end
        if (cfg.height == '0) begin
            eff_h = EW'(1);
        end else if ({1'b0, cfg.height} > EW'(HEIGHT_LIMIT)) begin
            eff_h = EW'(HEIGHT_LIMIT);
        end else begin
            eff_h = {1'b0, cfg.height};
        end
    end

    // Elastic stage handshake
    assign adv2     = st2_valid_reg & q_ready;
    assign rdy2     = ~st2_valid_reg | adv2;
    assign adv1     = st1_valid_reg & rdy2;
    assign rdy1     = ~st1_valid_reg | adv1;
    assign adv0     = st0_valid_reg & rdy1;
    assign in_ready = ~st0_valid_reg | adv0;
    assign accept   = in_valid & in_ready;

    // Counter advance on each accepted request
    assign col_inc = {1'b0, col_reg} + (CW+1)'(1);
    assign row_inc = {1'b0, row_reg} + (RW+1)'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (CMP_W'(col_inc) >= CMP_W'(eff_w)) begin
                col_next = '0;
                if (CMP_W'(row_inc) >= CMP_W'(eff_h)) begin
                    row_next = '0;
                end else begin
                    row_next = row_inc[RW-1:0];
                end
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_comb begin
        st0_valid_next = accept | (st0_valid_reg & ~adv0);
        st1_valid_next = adv0   | (st1_valid_reg & ~adv1);
        st2_valid_next = adv1   | (st2_valid_reg & ~adv2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            st0_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            st0_valid_reg <= st0_valid_next;
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
        end
    end

    // Grid tint in the active pixel format
    assign base = cfg.wide ? {8'h00, cfg.tint}
                           : {16'h0000, cfg.tint[23:19], cfg.tint[15:11], 1'b0,
                              cfg.tint[7:3]};
    assign p_in = cfg.wide ? in_pixel : (in_pixel & LOW16_MASK);

    // Stage 0: capture pixel and block origin
    always_ff @(posedge aclk) begin
        if (accept) begin
            st0_p_reg   <= p_in;
            st0_col_reg <= COORD_W'({col_reg, 2'b00});
            st0_row_reg <= COORD_W'({row_reg, 2'b00});
        end
    end

    // Stage 1: grid colour
    always_ff @(posedge aclk) begin
        if (adv0) begin
            st1_p_reg   <= st0_p_reg;
            st1_g_reg   <= pix_avg(st0_p_reg, base, cfg.wide, 1'b1);
            st1_col_reg <= st0_col_reg;
            st1_row_reg <= st0_row_reg;
        end
    end

    // Stage 2: pixel/grid mix
    always_ff @(posedge aclk) begin
        if (adv1) begin
            st2_p_reg   <= st1_p_reg;
            st2_g_reg   <= st1_g_reg;
            st2_mix_reg <= pix_avg(st1_p_reg, st1_g_reg, cfg.wide, 1'b0);
            st2_col_reg <= st1_col_reg;
            st2_row_reg <= st1_row_reg;
        end
    end

    // Shadow colour formed on the way into the queue
    assign q_valid          = st2_valid_reg;
    assign q_entry.pix_p    = st2_p_reg;
    assign q_entry.pix_g    = st2_g_reg;
    assign q_entry.pix_s    = pix_avg(st2_g_reg, st2_mix_reg, cfg.wide, 1'b0);
    assign q_entry.col_base = st2_col_reg;
    assign q_entry.row_base = st2_row_reg;

endmodule

`default_nettype wire

### hw/rtl/dmx_fifo.sv
// Two-entry queue of classified block entries between front and back end.
// Uses dmx_pkg for the entry type.
`default_nettype none

module dmx_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    input  wire dmx_pkg::blk_entry_t  wr_entry,
    output logic                      rd_valid,
    input  wire logic                 rd_pop,
    output dmx_pkg::blk_entry_t       rd_entry
);
    import dmx_pkg::*;

    blk_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_pop & rd_valid;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/dmx_back.sv
// Back end: walks the 4x4 block of the queue head and drives the output
// register, the 16 pixels of each entry in turn. Uses dmx_pkg.
`default_nettype none

module dmx_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_valid,
    output logic                                 q_pop,
    input  wire dmx_pkg::blk_entry_t             q_entry,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dmx_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tlast
);
    import dmx_pkg::*;

    logic [K_W-1:0]       k_reg, k_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    logic                 load, emit;
    logic [SUB_W-1:0]     br, bc;
    logic [PIX_W-1:0]     pix;
    logic [COORD_W-1:0]   col, row;

    assign load  = ~m_valid_reg | m_tready;
    assign emit  = load & q_valid;
    assign q_pop = emit & (k_reg == K_LAST);
    assign br    = k_reg[K_W-1:SUB_W];
    assign bc    = k_reg[SUB_W-1:0];

    // Colour selection: g p p p / s p p p / s p p p / s s s g
    always_comb begin
        if (k_reg == K_FIRST || k_reg == K_LAST) begin
            pix = q_entry.pix_g;
        end else if (bc == SUB_FIRST || br == SUB_LAST) begin
            pix = q_entry.pix_s;
        end else begin
            pix = q_entry.pix_p;
        end
        col = q_entry.col_base | COORD_W'(bc);
        row = q_entry.row_base | COORD_W'(br);
    end

    always_comb begin
        k_next       = emit ? k_reg + K_W'(1) : k_reg;
        m_valid_next = load ? q_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= {6'b000000, row, col, pix};
            m_last_reg <= (k_reg == K_LAST);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
